### hdl/dld_pkg.sv
// Shared types, constants and codes for the decimal long divider.
`default_nettype none
package dld_pkg;
	localparam int MaxDigits = 256;
	localparam logic [3:0] DigitMax = 4'd9;
	localparam logic [3:0] DigitBase = 4'd10;

	typedef enum logic [2:0] {
		MODE_LOAD_DVD = 3'd0,
		MODE_LOAD_DVS = 3'd1,
		MODE_START    = 3'd2,
		MODE_READ_Q   = 3'd3,
		MODE_READ_R   = 3'd4
	} mode_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] index;
		logic [3:0] digit;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [3:0] digit_res;
		logic [8:0] quotient_size;
		logic [8:0] remainder_size;
		logic       div_by_zero;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_VLEN,
		ST_DLEN,
		ST_COPY,
		ST_CMP,
		ST_SUB,
		ST_NEXTK,
		ST_QLEN,
		ST_RLEN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_init;   // load sweep counters for clear
		logic clr_step;
		logic vlen_init;
		logic vlen_step;
		logic dlen_init;
		logic dlen_step;
		logic copy_init;
		logic copy_step;
		logic div_init;   // set k, q
		logic cmp_init;
		logic cmp_step;
		logic sub_init;
		logic sub_step;
		logic next_k;     // write quotient digit, decrement k
		logic qlen_init;
		logic qlen_step;
		logic rlen_init;
		logic rlen_step;
		logic set_zero;
		logic finish;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic sweep_done;
		logic vl_zero;
		logic dl_ge_vl;
		logic cmp_done;
		logic cmp_ge;
		logic q_full;
		logic k_zero;
	} dp_sts_t;
endpackage
`default_nettype wire

### hdl/dld_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module dld_ram #(
	parameter int Width = 4,
	parameter int Depth = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### hdl/dld_ctrl.sv
// Controller state machine for the long division sequence.
`default_nettype none
module dld_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire dld_pkg::dp_sts_t  sts,
	output dld_pkg::dp_cmd_t       cmd,
	output logic                   running
);
	dld_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dld_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dld_pkg::ST_IDLE: if (go) state_d = dld_pkg::ST_CLEAR;
			dld_pkg::ST_CLEAR: if (sts.sweep_done) state_d = dld_pkg::ST_VLEN;
			dld_pkg::ST_VLEN: begin
				if (sts.sweep_done) begin
					state_d = dld_pkg::ST_DLEN;
				end
			end
			dld_pkg::ST_DLEN: begin
				if (sts.sweep_done) begin
					state_d = sts.vl_zero ? dld_pkg::ST_IDLE : dld_pkg::ST_COPY;
				end
			end
			dld_pkg::ST_COPY: begin
				if (sts.sweep_done) begin
					state_d = sts.dl_ge_vl ? dld_pkg::ST_CMP : dld_pkg::ST_QLEN;
				end
			end
			dld_pkg::ST_CMP: begin
				if (sts.q_full) begin
					state_d = dld_pkg::ST_NEXTK;
				end else if (sts.cmp_done) begin
					state_d = sts.cmp_ge ? dld_pkg::ST_SUB : dld_pkg::ST_NEXTK;
				end
			end
			dld_pkg::ST_SUB: if (sts.sweep_done) state_d = dld_pkg::ST_CMP;
			dld_pkg::ST_NEXTK: state_d = sts.k_zero ? dld_pkg::ST_QLEN : dld_pkg::ST_CMP;
			dld_pkg::ST_QLEN: if (sts.sweep_done) state_d = dld_pkg::ST_RLEN;
			dld_pkg::ST_RLEN: if (sts.sweep_done) state_d = dld_pkg::ST_IDLE;
			default: state_d = dld_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		running = (state_q != dld_pkg::ST_IDLE);
		case (state_q)
			dld_pkg::ST_IDLE: cmd.clr_init = go;
			dld_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				cmd.vlen_init = sts.sweep_done;
			end
			dld_pkg::ST_VLEN: begin
				cmd.vlen_step = 1'b1;
				cmd.dlen_init = sts.sweep_done;
			end
			dld_pkg::ST_DLEN: begin
				cmd.dlen_step = 1'b1;
				cmd.set_zero = sts.sweep_done && sts.vl_zero;
				cmd.copy_init = sts.sweep_done && !sts.vl_zero;
			end
			dld_pkg::ST_COPY: begin
				cmd.copy_step = 1'b1;
				cmd.div_init = sts.sweep_done && sts.dl_ge_vl;
				cmd.cmp_init = sts.sweep_done && sts.dl_ge_vl;
				cmd.qlen_init = sts.sweep_done && !sts.dl_ge_vl;
			end
			dld_pkg::ST_CMP: begin
				cmd.cmp_step = !sts.q_full;
				cmd.sub_init = !sts.q_full && sts.cmp_done && sts.cmp_ge;
			end
			dld_pkg::ST_SUB: begin
				cmd.sub_step = 1'b1;
				cmd.cmp_init = sts.sweep_done;
			end
			dld_pkg::ST_NEXTK: begin
				cmd.next_k = 1'b1;
				cmd.cmp_init = !sts.k_zero;
				cmd.qlen_init = sts.k_zero;
			end
			dld_pkg::ST_QLEN: begin
				cmd.qlen_step = 1'b1;
				cmd.rlen_init = sts.sweep_done;
			end
			dld_pkg::ST_RLEN: begin
				cmd.rlen_step = 1'b1;
				cmd.finish = sts.sweep_done;
			end
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

### hdl/dld_dp.sv
// Datapath: digit memories, sweep counter, digit compare and subtract.
`default_nettype none
module dld_dp #(
	parameter int MaxDigits = dld_pkg::MaxDigits
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire dld_pkg::cmd_t     item,
	input  wire dld_pkg::dp_cmd_t  cmd,
	output dld_pkg::dp_sts_t       sts,
	output logic                   strobe,
	output dld_pkg::res_t          result
);
	localparam int AW = $clog2(MaxDigits);
	localparam int LW = $clog2(MaxDigits + 1);
	localparam logic [LW-1:0] LenMax = LW'(MaxDigits);

	// Sweep pointer runs over addresses; the registered read is covered by
	// issuing address p and using its data on the next cycle (tracked by act_s1/addr_s1).
	logic [LW-1:0] ptr_q;      // counts down; address is ptr_q-1 (MaxDigits-ptr_q when subtracting)
	logic          act_s1;
	logic [AW-1:0] addr_s1;
	logic          first_q;
	logic [LW-1:0] dvd_len_q, dvs_len_q, qlen_q, rlen_q, vl_q, dl_q, found_q;
	logic          zero_q;
	logic [LW-1:0] k_q;
	logic [3:0]    q_q;
	logic          borrow_q;
	logic          cmp_dec_q, cmp_ge_q;

	// memory ports
	logic          dvd_we, dvs_we, qm_we, rm_we;
	logic [AW-1:0] dvd_wa, dvs_wa, qm_wa, rm_wa, dvd_ra, dvs_ra, qm_ra, rm_ra;
	logic [3:0]    dvd_wd, dvs_wd, qm_wd, rm_wd, dvd_rd, dvs_rd, qm_rd, rm_rd;

	dld_ram #(.Width(4), .Depth(MaxDigits)) u_dvd (.clk, .we(dvd_we), .waddr(dvd_wa),
		.wdata(dvd_wd), .raddr(dvd_ra), .rdata(dvd_rd));
	dld_ram #(.Width(4), .Depth(MaxDigits)) u_dvs (.clk, .we(dvs_we), .waddr(dvs_wa),
		.wdata(dvs_wd), .raddr(dvs_ra), .rdata(dvs_rd));
	dld_ram #(.Width(4), .Depth(MaxDigits)) u_qm (.clk, .we(qm_we), .waddr(qm_wa),
		.wdata(qm_wd), .raddr(qm_ra), .rdata(qm_rd));
	dld_ram #(.Width(4), .Depth(MaxDigits)) u_rm (.clk, .we(rm_we), .waddr(rm_wa),
		.wdata(rm_wd), .raddr(rm_ra), .rdata(rm_rd));

	logic          in_range;
	logic [3:0]    dg_sat;
	logic [AW-1:0] item_addr;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] sweep_addr;
	logic          sweeping;
	logic          any_step;
	logic [LW:0]   dv_idx;     // address minus k, for aligned divisor digit
	logic          dv_in;
	logic [3:0]    dv_digit;
	logic [4:0]    diff;
	logic          rd_pend_q;
	logic          rd_q_sel_q;
	logic          rd_in_q;
	logic          reset_val_q;  // quotient/remainder stores still at reset value

	assign in_range = (32'(item.index) < MaxDigits);
	assign dg_sat = (item.digit > dld_pkg::DigitMax) ? dld_pkg::DigitMax : item.digit;
	assign item_addr = AW'(item.index);
	assign cur_addr = AW'(ptr_q - LW'(1));
	// subtract walks upward so the borrow moves from low to high digits
	assign sweep_addr = cmd.sub_step ? AW'(LenMax - ptr_q) : cur_addr;
	assign any_step = cmd.clr_step | cmd.vlen_step | cmd.dlen_step | cmd.copy_step
		| cmd.cmp_step | cmd.sub_step | cmd.qlen_step | cmd.rlen_step;
	assign sweeping = any_step && (ptr_q != '0);

	// aligned divisor digit for the address in stage 1
	assign dv_idx = {1'b0, LW'(addr_s1)} - {1'b0, k_q};
	assign dv_in = ({1'b0, LW'(addr_s1)} >= {1'b0, k_q}) && (dv_idx < {1'b0, vl_q});
	assign dv_digit = dv_in ? dvs_rd : 4'd0;
	assign diff = {1'b0, rm_rd} - {1'b0, dv_digit} - {4'd0, borrow_q};

	always_comb begin
		dvd_we = 1'b0; dvd_wa = item_addr; dvd_wd = dg_sat;
		dvs_we = 1'b0; dvs_wa = item_addr; dvs_wd = dg_sat;
		qm_we = 1'b0; qm_wa = cur_addr; qm_wd = 4'd0;
		rm_we = 1'b0; rm_wa = cur_addr; rm_wd = 4'd0;
		dvd_ra = sweep_addr; qm_ra = sweep_addr; rm_ra = sweep_addr;
		dvs_ra = sweep_addr;
		if (accept && in_range) begin
			dvd_we = (item.mode == dld_pkg::MODE_LOAD_DVD);
			dvs_we = (item.mode == dld_pkg::MODE_LOAD_DVS);
			qm_ra = item_addr;
			rm_ra = item_addr;
		end
		if (cmd.clr_step && sweeping) begin
			qm_we = 1'b1;
			rm_we = 1'b1;
		end
		if (cmd.sub_step || cmd.cmp_step) begin
			dvs_ra = AW'(LW'(sweep_addr) - k_q);
		end
		if (cmd.copy_step && act_s1) begin
			rm_we = 1'b1; rm_wa = addr_s1; rm_wd = (LW'(addr_s1) < dl_q) ? dvd_rd : 4'd0;
		end
		if (cmd.sub_step && act_s1) begin
			rm_we = 1'b1; rm_wa = addr_s1;
			rm_wd = diff[4] ? 4'(diff + 5'(dld_pkg::DigitBase)) : diff[3:0];
		end
		if (cmd.next_k) begin
			qm_we = 1'b1; qm_wa = AW'(k_q); qm_wd = q_q;
		end
	end

	// sweep directions: clear/len/cmp go top-down; copy too; subtract bottom-up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0; act_s1 <= 1'b0; first_q <= 1'b0;
			dvd_len_q <= LW'(1); dvs_len_q <= LW'(1);
			qlen_q <= LW'(1); rlen_q <= LW'(1); zero_q <= 1'b0;
			vl_q <= '0; dl_q <= '0; found_q <= '0; k_q <= '0; q_q <= '0;
			borrow_q <= 1'b0; cmp_dec_q <= 1'b0; cmp_ge_q <= 1'b0;
			rd_pend_q <= 1'b0; rd_q_sel_q <= 1'b0; rd_in_q <= 1'b0;
			reset_val_q <= 1'b1; addr_s1 <= '0;
		end else begin
			rd_pend_q <= 1'b0;
			if (accept) begin
				if (in_range && item.last && item.mode == dld_pkg::MODE_LOAD_DVD)
					dvd_len_q <= LW'(item.index) + LW'(1);
				if (in_range && item.last && item.mode == dld_pkg::MODE_LOAD_DVS)
					dvs_len_q <= LW'(item.index) + LW'(1);
				rd_pend_q <= (item.mode == dld_pkg::MODE_READ_Q)
					|| (item.mode == dld_pkg::MODE_READ_R);
				rd_q_sel_q <= (item.mode == dld_pkg::MODE_READ_Q);
				rd_in_q <= in_range;
			end
			// drop a compare read still in flight when the subtract sweep starts
			act_s1 <= sweeping && !cmd.sub_init;
			if (sweeping) begin
				addr_s1 <= sweep_addr;
				ptr_q <= ptr_q - LW'(1);
			end
			if (cmd.clr_init) begin
				ptr_q <= LenMax; reset_val_q <= 1'b0;
			end
			if (cmd.vlen_init) begin
				ptr_q <= (dvs_len_q > LenMax) ? LenMax : dvs_len_q;
				found_q <= '0; first_q <= 1'b1;
			end
			if (cmd.dlen_init) begin
				vl_q <= found_q;
				ptr_q <= dvd_len_q; found_q <= '0; first_q <= 1'b1;
			end
			if (cmd.copy_init) begin
				dl_q <= found_q; ptr_q <= found_q;
			end
			if (cmd.qlen_init || cmd.rlen_init) begin
				ptr_q <= LenMax; found_q <= '0; first_q <= 1'b1;
			end
			if (cmd.qlen_init) begin
				zero_q <= 1'b0;
			end
			if (cmd.rlen_init) begin
				qlen_q <= (found_q == '0) ? LW'(1) : found_q;
			end
			// first nonzero digit seen from the top fixes the length
			if ((cmd.vlen_step || cmd.dlen_step || cmd.qlen_step || cmd.rlen_step)
				&& act_s1 && first_q) begin
				if ((cmd.vlen_step ? dvs_rd : cmd.dlen_step ? dvd_rd
					: cmd.qlen_step ? qm_rd : rm_rd) != 4'd0) begin
					found_q <= LW'(addr_s1) + LW'(1);
					first_q <= 1'b0;
				end
			end
			if (cmd.div_init) begin
				k_q <= dl_q - vl_q; q_q <= '0;
			end
			if (cmd.cmp_init) begin
				ptr_q <= LenMax; cmp_dec_q <= 1'b0; cmp_ge_q <= 1'b1;
			end
			if (cmd.cmp_step && act_s1 && !cmp_dec_q && rm_rd != dv_digit) begin
				cmp_dec_q <= 1'b1; cmp_ge_q <= (rm_rd > dv_digit);
			end
			if (cmd.sub_init) begin
				ptr_q <= LenMax; borrow_q <= 1'b0; q_q <= q_q + 4'd1;
			end
			if (cmd.sub_step && act_s1) begin
				borrow_q <= diff[4];
			end
			if (cmd.next_k) begin
				k_q <= k_q - LW'(1); q_q <= '0;
			end
			if (cmd.set_zero) begin
				zero_q <= 1'b1; qlen_q <= LW'(1); rlen_q <= LW'(1);
			end
			if (cmd.finish) begin
				rlen_q <= (found_q == '0) ? LW'(1) : found_q;
			end
		end
	end

	// subtract maps the descending pointer to an ascending address: MaxDigits - ptr
	assign sts.sweep_done = any_step && (ptr_q == '0) && !act_s1;
	assign sts.vl_zero = (vl_q == '0);
	assign sts.dl_ge_vl = (found_q >= vl_q);
	assign sts.cmp_done = cmd.cmp_step && (cmp_dec_q || ((ptr_q == '0) && !act_s1));
	assign sts.cmp_ge = cmp_ge_q;
	assign sts.q_full = (q_q == dld_pkg::DigitMax);
	assign sts.k_zero = (k_q == '0);

	assign strobe = rd_pend_q;
	always_comb begin
		result.digit_res = (!rd_in_q || reset_val_q) ? 4'd0 : (rd_q_sel_q ? qm_rd : rm_rd);
		result.quotient_size = 9'(qlen_q);
		result.remainder_size = 9'(rlen_q);
		result.div_by_zero = zero_q;
	end
endmodule
`default_nettype wire

### hdl/decimal_long_divider.sv
// Top level of the decimal long divider: controller plus datapath.
// Load and read transactions are accepted while busy is low; a read result strobes on the next cycle.
// Start holds busy for a clear sweep and length scans, then unless the divisor is zero a copy,
// per quotient digit up to nine compare and nine subtract sweeps, then two closing length scans.
// Throughput: one load or read per cycle while busy is low; results cannot be stalled.
// Reset (arst_n low) clears lengths to one, quotient and remainder read as zero, flag low.
`default_nettype none
module decimal_long_divider #(
	parameter int MAX_DIGITS = dld_pkg::MaxDigits
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire dld_pkg::cmd_t  cmd,
	output logic                busy,
	output logic                strobe,
	output dld_pkg::res_t       result
);
	dld_pkg::dp_cmd_t dcmd;
	dld_pkg::dp_sts_t dsts;
	logic accept, go;

	assign accept = start && !busy;
	assign go = accept && (cmd.mode == dld_pkg::MODE_START);

	dld_ctrl u_ctrl (.clk, .arst_n, .go, .sts(dsts), .cmd(dcmd), .running(busy));
	dld_dp #(.MaxDigits(MAX_DIGITS)) u_dp (.clk, .arst_n, .accept, .item(cmd),
		.cmd(dcmd), .sts(dsts), .strobe, .result);

`ifndef SYNTHESIS
	a_no_strobe_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> !strobe) else $error("strobe at division start");
	a_size_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.quotient_size != 9'd0 && result.remainder_size != 9'd0))
		else $error("zero size reported");
	a_zero_quot: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.div_by_zero) |-> result.quotient_size == 9'd1)
		else $error("divide by zero size");
`endif
endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the decimal long divider: digit loads, divisions, checked digit reads.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import dld_pkg::*;

	class division_tracker;
		bit [3:0] dvd[MaxDigits];
		bit [3:0] dvs[MaxDigits];
		bit [3:0] quo[MaxDigits];
		bit [3:0] rem[MaxDigits];
		int dvd_len, dvs_len, quo_len, rem_len;
		bit zero_div;
		res_t read_q[$];
		int errors;

		function new();
			dvd_len = 1;
			dvs_len = 1;
			quo_len = 1;
			rem_len = 1;
			zero_div = 0;
			errors = 0;
			foreach (quo[i]) begin
				quo[i] = 0;
				rem[i] = 0;
				dvd[i] = 0;
				dvs[i] = 0;
			end
		endfunction

		function int sig_len(bit [3:0] a[MaxDigits], int n);
			int m;
			m = (n > MaxDigits) ? MaxDigits : n;
			while (m > 0 && a[m - 1] == 0) m--;
			return m;
		endfunction

		function int dvs_at(int i, int k, int vl);
			if (i < k || i - k >= vl) return 0;
			return dvs[i - k];
		endfunction

		function bit rem_ge(int k, int vl);
			int a, b;
			for (int i = MaxDigits - 1; i >= 0; i--) begin
				a = rem[i];
				b = dvs_at(i, k, vl);
				if (a != b) return a > b;
			end
			return 1;
		endfunction

		function void subtract(int k, int vl);
			int d, borrow;
			borrow = 0;
			for (int i = k; i < MaxDigits; i++) begin
				d = rem[i] - dvs_at(i, k, vl) - borrow;
				borrow = 0;
				if (d < 0) begin
					d += 10;
					borrow = 1;
				end
				rem[i] = 4'(d);
			end
		endfunction

		function void divide();
			int vl, dl, k, q, n;
			foreach (quo[i]) begin
				quo[i] = 0;
				rem[i] = 0;
			end
			vl = sig_len(dvs, dvs_len);
			if (vl == 0) begin
				zero_div = 1;
				quo_len = 1;
				rem_len = 1;
				return;
			end
			zero_div = 0;
			dl = sig_len(dvd, dvd_len);
			for (int i = 0; i < dl; i++) rem[i] = dvd[i];
			if (dl >= vl) begin
				k = dl - vl + 1;
				while (k > 0) begin
					k--;
					q = 0;
					while (q < 9 && rem_ge(k, vl)) begin
						subtract(k, vl);
						q++;
					end
					quo[k] = 4'(q);
				end
			end
			n = sig_len(quo, MaxDigits);
			quo_len = n ? n : 1;
			n = sig_len(rem, MaxDigits);
			rem_len = n ? n : 1;
		endfunction

		function void note_cmd(cmd_t c);
			bit [3:0] d;
			res_t r;
			d = (c.digit > DigitMax) ? DigitMax : c.digit;
			case (c.mode)
				MODE_LOAD_DVD: begin
					dvd[c.index] = d;
					if (c.last) dvd_len = c.index + 1;
				end
				MODE_LOAD_DVS: begin
					dvs[c.index] = d;
					if (c.last) dvs_len = c.index + 1;
				end
				MODE_START: divide();
				MODE_READ_Q, MODE_READ_R: begin
					r.digit_res = (c.mode == MODE_READ_Q) ? quo[c.index] : rem[c.index];
					r.quotient_size = 9'(quo_len);
					r.remainder_size = 9'(rem_len);
					r.div_by_zero = zero_div;
					read_q.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check_read(res_t got);
			res_t exp;
			if (read_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
				return;
			end
			exp = read_q.pop_front();
			if (got.digit_res !== exp.digit_res || got.quotient_size !== exp.quotient_size ||
					got.remainder_size !== exp.remainder_size ||
					got.div_by_zero !== exp.div_by_zero) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected digit %0d qs %0d rs %0d dz %0d, got %0d %0d %0d %0d",
						exp.digit_res, exp.quotient_size, exp.remainder_size, exp.div_by_zero,
						got.digit_res, got.quotient_size, got.remainder_size, got.div_by_zero);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	cmd_t cmd = '0;
	logic busy;
	logic strobe;
	res_t result;

	division_tracker tracker = new();
	int sent = 0;
	int idle_pct = 0;

	decimal_long_divider DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.strobe(strobe),
		.result(result)
	);

	always #6 clk = ~clk;

	// busy and strobe are stable mid-cycle
	always @(negedge clk) begin
		if (arst_n && strobe === 1'b1) tracker.check_read(result);
	end

	task automatic issue(logic [2:0] m, int idx, int dg, bit lst);
		cmd_t c;
		int gap;
		logic b;
		c.mode = m;
		c.index = 8'(idx);
		c.digit = 4'(dg);
		c.last = lst;
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		forever begin
			@(negedge clk);
			b = busy;
			@(posedge clk);
			if (!b) break;
		end
		tracker.note_cmd(c);
		sent++;
	endtask

	// write an operand: up to four random digits at random positions, then the top digit with last
	task automatic load_operand(logic [2:0] m, int len, bit nz_top);
		int n;
		n = $urandom_range(0, (len < 4) ? len : 4);
		repeat (n) issue(m, $urandom_range(0, len - 1), $urandom_range(0, 15), 1'b0);
		issue(m, len - 1, nz_top ? $urandom_range(1, 9) : $urandom_range(0, 15), 1'b1);
	endtask

	task automatic division_round(bit wide, bit zero_dvs);
		int dl, vl, nrd;
		if (wide) begin
			dl = $urandom_range(250, MaxDigits);
			vl = dl - $urandom_range(0, 1);
			load_operand(MODE_LOAD_DVD, dl, 1'b0);
			load_operand(MODE_LOAD_DVS, vl, 1'b1);
		end else begin
			dl = $urandom_range(1, 6);
			vl = $urandom_range(1, (dl + 1 > 6) ? 6 : dl + 1);
			load_operand(MODE_LOAD_DVD, dl, 1'($urandom_range(1)));
			if (zero_dvs) issue(MODE_LOAD_DVS, 0, 0, 1'b1);
			else load_operand(MODE_LOAD_DVS, vl, $urandom_range(3) != 0);
		end
		issue(MODE_START, $urandom_range(0, 255), $urandom_range(0, 15),
			1'($urandom_range(1)));
		nrd = $urandom_range(4, 12);
		repeat (nrd) begin
			issue($urandom_range(1) ? MODE_READ_Q : MODE_READ_R,
				($urandom_range(7) == 0) ? $urandom_range(0, 255) :
					$urandom_range(0, wide ? 255 : 7),
				$urandom_range(0, 15), 1'($urandom_range(1)));
			if ($urandom_range(15) == 0)
				issue(3'($urandom_range(5, 7)), $urandom_range(0, 255), $urandom_range(0, 15),
					1'($urandom_range(1)));
		end
	endtask

	initial begin
		int wait_cycles;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state, unused modes
		issue(MODE_READ_Q, 0, 0, 1'b0);
		issue(MODE_READ_R, 255, 15, 1'b1);
		issue(3'd5, 3, 9, 1'b1);
		issue(3'd6, 255, 15, 1'b0);
		issue(3'd7, 0, 0, 1'b1);

		// fill every operand digit so no division ever sees an unwritten one
		for (int i = 0; i < MaxDigits; i++) begin
			issue(MODE_LOAD_DVD, i, $urandom_range(0, 15), 1'b0);
			issue(MODE_LOAD_DVS, i, $urandom_range(0, 15), 1'b0);
		end
		issue(MODE_START, 0, 0, 1'b0);
		issue(MODE_READ_Q, 0, 0, 1'b0);
		issue(MODE_READ_R, 1, 0, 1'b0);
		division_round(0, 1);
		division_round(1, 0);
		division_round(0, 0);

		while (sent < 1350) begin
			case ((sent / 120) % 4)
				0: idle_pct = 0;
				1: idle_pct = 49;
				2: idle_pct = 0;
				default: idle_pct = 30;
			endcase
			division_round($urandom_range(24) == 0, $urandom_range(11) == 0);
		end
		start <= 1'b0;

		wait_cycles = 0;
		while (tracker.read_q.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.read_q.size() == 0)
			$display("** decimal_long_divider: PASSED **");
		else
			$display("** decimal_long_divider: FAILED **");
		$finish;
	end

	initial begin
		#300ms;
		$display("** decimal_long_divider: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
